// ===== rtl/fttacc_pkg.sv =====
// Shared widths, constants and types for the fixed-timestep tick accumulator.
package fttacc_pkg;

   // Field and register widths
   localparam int NOW_W      = 63;
   localparam int RATE_W     = 32;
   localparam int SCALE_W    = 16;
   localparam int ELAPSED_W  = 30;
   localparam int WHOLE_W    = 7;
   localparam int FPS_W      = 30;
   localparam int ACC_W      = 48;
   localparam int ACC_FRAC_W = 32;
   localparam int ACC_INT_W  = ACC_W - ACC_FRAC_W;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 1;

   // Derived datapath widths: scale * rate, times elapsed, then Q16.32 alignment
   localparam int SR_W    = RATE_W + SCALE_W;
   localparam int PROD_W  = SR_W + ELAPSED_W;
   localparam int ALIGN_W = 8;
   localparam int DVD_W   = PROD_W + ALIGN_W;

   // Constants
   localparam logic [ELAPSED_W-1:0] NS_PER_SEC  = 30'd1000000000;
   localparam logic [WHOLE_W-1:0]   MAX_TICKS   = 7'd100;
   localparam logic [ACC_W-1:0]     ACC_MAX     = '1;
   localparam logic [RATE_W-1:0]    RATE_RESET  = 32'd1310720;
   localparam logic [SCALE_W-1:0]   SCALE_RESET = 16'd256;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_RATE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_SCALE = 1'b1;

   // Status of a serial arithmetic unit
   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

endpackage

// ===== rtl/fttacc_mul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module fttacc_mul #(
   parameter int A_W = fttacc_pkg::RATE_W,
   parameter int B_W = fttacc_pkg::SCALE_W
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [A_W-1:0]              a,
   input  logic [B_W-1:0]              b,
   output fttacc_pkg::unit_status_type status,
   output logic [A_W+B_W-1:0]          product
);

   localparam int CNT_W = $clog2(B_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [A_W-1:0]   a_ff, a_in;
   logic [A_W-1:0]   hi_ff, hi_in;
   logic [B_W-1:0]   lo_ff, lo_in;
   logic [A_W:0]     sum;

   // Add the multiplicand when the low multiplier bit is set
   assign sum = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, a_ff} : '0);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      if (start) begin
         a_in    = a;
         hi_in   = '0;
         lo_in   = b;
         cnt_in  = CNT_W'(B_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // Shift the partial product right by one bit
         hi_in  = sum[A_W:1];
         lo_in  = {sum[0], lo_ff[B_W-1:1]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff  <= a_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign product     = {hi_ff, lo_ff};

endmodule

// ===== rtl/fttacc_div.sv =====
// Restoring divider, one quotient bit per cycle.
module fttacc_div #(
   parameter int N_W = fttacc_pkg::FPS_W,
   parameter int D_W = fttacc_pkg::ELAPSED_W
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [N_W-1:0]              dividend,
   input  logic [D_W-1:0]              divisor,
   output fttacc_pkg::unit_status_type status,
   output logic [N_W-1:0]              quotient
);

   localparam int CNT_W = $clog2(N_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [N_W-1:0]   quo_ff, quo_in;
   logic [D_W-1:0]   rem_ff, rem_in;
   logic [D_W-1:0]   dsr_ff, dsr_in;
   logic [D_W:0]     trial;
   logic [D_W:0]     diff;
   logic             fits;

   // Bring down the next dividend bit and try the subtraction
   assign trial = {rem_ff, quo_ff[N_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CNT_W'(N_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[N_W-2:0], fits};
         rem_in = fits ? diff[D_W-1:0] : trial[D_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

// ===== rtl/fixed_timestep_tick_accumulator.sv =====
// Top level of the fixed-timestep tick accumulator: control, state and result register.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_ready  req_now_ns
//   rsp_      out        rsp_valid/rsp_ready  rsp_whole_ticks, rsp_frame_rate, rsp_partial_tick
//   csr_      in         csr_we               csr_index, csr_wdata
//
// A new transaction is accepted only once the previous one is done: the scale-by-rate
// multiplier runs 16 steps, the elapsed-time multiplier 30 and the divide by 1e9 86, plus
// control states; the frame-rate divider runs alongside the multipliers.
// Reset is synchronous, clears state and restores the reset configuration; the first
// transaction after it only records the reference time. A result waits in the output register
// while rsp_ready is low; the next transaction is accepted and parks until that frees up.
module fixed_timestep_tick_accumulator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [fttacc_pkg::NOW_W-1:0]        req_now_ns,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [fttacc_pkg::WHOLE_W-1:0]      rsp_whole_ticks,
   output logic [fttacc_pkg::FPS_W-1:0]        rsp_frame_rate,
   output logic [fttacc_pkg::ACC_W-1:0]        rsp_partial_tick,
   input  logic                                csr_we,
   input  logic [fttacc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fttacc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_SR,
      ST_MUL_PROD,
      ST_DIVIDE,
      ST_ADD,
      ST_TRIM,
      ST_FINISH
   } state_type;

   state_type                              state_ff, state_in;
   logic                                   primed_ff, primed_in;
   logic [fttacc_pkg::NOW_W-1:0]           prev_ff, prev_in;
   logic [fttacc_pkg::ACC_W-1:0]           acc_ff, acc_in;
   logic [fttacc_pkg::ELAPSED_W-1:0]       elapsed_ff, elapsed_in;
   logic [fttacc_pkg::RATE_W-1:0]          rate_ff, rate_in;
   logic [fttacc_pkg::SCALE_W-1:0]         scale_ff, scale_in;
   logic                                   start_sr_ff, start_sr_in;
   logic                                   start_prod_ff, start_prod_in;
   logic                                   start_inc_ff, start_inc_in;
   logic                                   start_fps_ff, start_fps_in;
   logic [fttacc_pkg::WHOLE_W-1:0]         res_whole_ff, res_whole_in;
   logic [fttacc_pkg::FPS_W-1:0]           res_fps_ff, res_fps_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic [fttacc_pkg::WHOLE_W-1:0]         rsp_whole_ff, rsp_whole_in;
   logic [fttacc_pkg::FPS_W-1:0]           rsp_fps_ff, rsp_fps_in;
   logic [fttacc_pkg::ACC_W-1:0]           rsp_part_ff, rsp_part_in;

   fttacc_pkg::unit_status_type            sr_stat, prod_stat, inc_stat, fps_stat;
   logic [fttacc_pkg::SR_W-1:0]            sr_product;
   logic [fttacc_pkg::PROD_W-1:0]          prod_product;
   logic [fttacc_pkg::DVD_W-1:0]           inc_quotient;
   logic [fttacc_pkg::FPS_W-1:0]           fps_quotient;

   logic                                   accept;
   logic                                   later;
   logic [fttacc_pkg::NOW_W-1:0]           diff;
   logic [fttacc_pkg::ELAPSED_W-1:0]       elapsed_new;
   logic [fttacc_pkg::ACC_W-1:0]           headroom;
   logic                                   saturate;
   logic [fttacc_pkg::ACC_INT_W-1:0]       avail;
   logic [fttacc_pkg::WHOLE_W-1:0]         whole;
   logic                                   out_free;

   // Multiply tick rate by time scale
   fttacc_mul #(
      .A_W (fttacc_pkg::RATE_W),
      .B_W (fttacc_pkg::SCALE_W)
   ) u_mul_sr (
      .clock   (clock),
      .reset   (reset),
      .start   (start_sr_ff),
      .a       (rate_ff),
      .b       (scale_ff),
      .status  (sr_stat),
      .product (sr_product)
   );

   // Multiply by the clamped elapsed time
   fttacc_mul #(
      .A_W (fttacc_pkg::SR_W),
      .B_W (fttacc_pkg::ELAPSED_W)
   ) u_mul_prod (
      .clock   (clock),
      .reset   (reset),
      .start   (start_prod_ff),
      .a       (sr_product),
      .b       (elapsed_ff),
      .status  (prod_stat),
      .product (prod_product)
   );

   // Align to Q16.32 and divide by one second in nanoseconds
   fttacc_div #(
      .N_W (fttacc_pkg::DVD_W),
      .D_W (fttacc_pkg::ELAPSED_W)
   ) u_div_inc (
      .clock    (clock),
      .reset    (reset),
      .start    (start_inc_ff),
      .dividend ({prod_product, {fttacc_pkg::ALIGN_W{1'b0}}}),
      .divisor  (fttacc_pkg::NS_PER_SEC),
      .status   (inc_stat),
      .quotient (inc_quotient)
   );

   // Frame rate: one second over elapsed time
   fttacc_div #(
      .N_W (fttacc_pkg::FPS_W),
      .D_W (fttacc_pkg::ELAPSED_W)
   ) u_div_fps (
      .clock    (clock),
      .reset    (reset),
      .start    (start_fps_ff),
      .dividend (fttacc_pkg::NS_PER_SEC),
      .divisor  (elapsed_ff),
      .status   (fps_stat),
      .quotient (fps_quotient)
   );

   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Clamp elapsed time to 0..1e9 ns
   assign later = req_now_ns > prev_ff;
   assign diff  = req_now_ns - prev_ff;
   always_comb begin
      if (!later) begin
         elapsed_new = '0;
      end else if (diff > fttacc_pkg::NOW_W'(fttacc_pkg::NS_PER_SEC)) begin
         elapsed_new = fttacc_pkg::NS_PER_SEC;
      end else begin
         elapsed_new = diff[fttacc_pkg::ELAPSED_W-1:0];
      end
   end

   // Saturate the accumulator when the increment reaches its headroom
   assign headroom = fttacc_pkg::ACC_MAX - acc_ff;
   assign saturate = (|inc_quotient[fttacc_pkg::DVD_W-1:fttacc_pkg::ACC_W])
                     || (inc_quotient[fttacc_pkg::ACC_W-1:0] >= headroom);

   // Cap whole ticks at the maximum per frame
   assign avail = acc_ff[fttacc_pkg::ACC_W-1:fttacc_pkg::ACC_FRAC_W];
   assign whole = (avail > fttacc_pkg::ACC_INT_W'(fttacc_pkg::MAX_TICKS))
                  ? fttacc_pkg::MAX_TICKS : avail[fttacc_pkg::WHOLE_W-1:0];

   always_comb begin
      state_in      = state_ff;
      primed_in     = primed_ff;
      prev_in       = prev_ff;
      acc_in        = acc_ff;
      elapsed_in    = elapsed_ff;
      rate_in       = rate_ff;
      scale_in      = scale_ff;
      start_sr_in   = 1'b0;
      start_prod_in = 1'b0;
      start_inc_in  = 1'b0;
      start_fps_in  = 1'b0;
      res_whole_in  = res_whole_ff;
      res_fps_in    = res_fps_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_whole_in  = rsp_whole_ff;
      rsp_fps_in    = rsp_fps_ff;
      rsp_part_in   = rsp_part_ff;

      // Take configuration writes
      if (csr_we) begin
         case (csr_index)
            fttacc_pkg::CSR_TICK_RATE:  rate_in  = csr_wdata;
            fttacc_pkg::CSR_TIME_SCALE: scale_in = csr_wdata[fttacc_pkg::SCALE_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               prev_in = req_now_ns;
               if (primed_ff) begin
                  elapsed_in   = elapsed_new;
                  start_sr_in  = 1'b1;
                  start_fps_in = 1'b1;
                  state_in     = ST_MUL_SR;
               end else begin
                  // First transaction only records the reference time
                  primed_in    = 1'b1;
                  res_whole_in = '0;
                  res_fps_in   = '0;
                  state_in     = ST_FINISH;
               end
            end
         end
         ST_MUL_SR: begin
            if (sr_stat.done) begin
               start_prod_in = 1'b1;
               state_in      = ST_MUL_PROD;
            end
         end
         ST_MUL_PROD: begin
            if (prod_stat.done) begin
               start_inc_in = 1'b1;
               state_in     = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (inc_stat.done) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            acc_in     = saturate ? fttacc_pkg::ACC_MAX
                                  : acc_ff + inc_quotient[fttacc_pkg::ACC_W-1:0];
            res_fps_in = (elapsed_ff == '0) ? '0 : fps_quotient;
            state_in   = ST_TRIM;
         end
         ST_TRIM: begin
            // Remove only the emitted ticks
            acc_in       = {avail - fttacc_pkg::ACC_INT_W'(whole),
                            acc_ff[fttacc_pkg::ACC_FRAC_W-1:0]};
            res_whole_in = whole;
            state_in     = ST_FINISH;
         end
         ST_FINISH: begin
            // Load the output register once it is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_whole_in = res_whole_ff;
               rsp_fps_in   = res_fps_ff;
               rsp_part_in  = acc_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         primed_ff     <= 1'b0;
         prev_ff       <= '0;
         acc_ff        <= '0;
         rate_ff       <= fttacc_pkg::RATE_RESET;
         scale_ff      <= fttacc_pkg::SCALE_RESET;
         start_sr_ff   <= 1'b0;
         start_prod_ff <= 1'b0;
         start_inc_ff  <= 1'b0;
         start_fps_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         primed_ff     <= primed_in;
         prev_ff       <= prev_in;
         acc_ff        <= acc_in;
         rate_ff       <= rate_in;
         scale_ff      <= scale_in;
         start_sr_ff   <= start_sr_in;
         start_prod_ff <= start_prod_in;
         start_inc_ff  <= start_inc_in;
         start_fps_ff  <= start_fps_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      elapsed_ff   <= elapsed_in;
      res_whole_ff <= res_whole_in;
      res_fps_ff   <= res_fps_in;
      rsp_whole_ff <= rsp_whole_in;
      rsp_fps_ff   <= rsp_fps_in;
      rsp_part_ff  <= rsp_part_in;
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_whole_ticks  = rsp_whole_ff;
   assign rsp_frame_rate   = rsp_fps_ff;
   assign rsp_partial_tick = rsp_part_ff;

endmodule

// ===== rtl/fttacc_checker.sv =====
// Port-level checks for the fixed-timestep tick accumulator, bound to the top level.
module fttacc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic [fttacc_pkg::NOW_W-1:0]        req_now_ns,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [fttacc_pkg::WHOLE_W-1:0]      rsp_whole_ticks,
   input logic [fttacc_pkg::FPS_W-1:0]        rsp_frame_rate,
   input logic [fttacc_pkg::ACC_W-1:0]        rsp_partial_tick
);

   // Never emit more than the tick cap
   a_tick_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_whole_ticks <= fttacc_pkg::MAX_TICKS)
      else $error("whole ticks above cap");

   // Frame rate never exceeds one per nanosecond
   a_fps_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_frame_rate <= fttacc_pkg::NS_PER_SEC)
      else $error("frame rate out of range");

   // Drop ready after a transaction is taken: one item in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready held after accept");

   // Hold an offered request until it is taken
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_ready) |=> (req_valid && $stable(req_now_ns)))
      else $error("offered request changed");

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_whole_ticks)
         && $stable(rsp_frame_rate) && $stable(rsp_partial_tick)))
      else $error("stalled result changed");

endmodule

bind fixed_timestep_tick_accumulator fttacc_checker u_fttacc_checker (.*);

// ===== tb/fixed_timestep_tick_accumulator_tb.sv =====
`timescale 1ns / 100ps
// Testbench for the fixed-timestep tick accumulator: directed table, back-pressure, random phases.
module fixed_timestep_tick_accumulator_tb;

   localparam int LONG_HOLD   = 3000;
   localparam int TAIL_CYCLES = 300;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 75;
   localparam logic [63:0] SEC_NS = 64'd1000000000;

   typedef struct packed {
      logic [fttacc_pkg::WHOLE_W-1:0] whole;
      logic [fttacc_pkg::FPS_W-1:0]   fps;
      logic [fttacc_pkg::ACC_W-1:0]   partial;
   } frame_type;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type                       kind;
      logic [fttacc_pkg::NOW_W-1:0]       stamp;
      logic [fttacc_pkg::CSR_IDX_W-1:0]   index;
      logic [fttacc_pkg::CSR_DATA_W-1:0]  data;
      bit                                 typed;
      frame_type                          frame;
   } stim_row_type;

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_ready;
   logic [fttacc_pkg::NOW_W-1:0]      req_now_ns;
   logic                              rsp_valid;
   logic                              rsp_ready;
   logic [fttacc_pkg::WHOLE_W-1:0]    rsp_whole_ticks;
   logic [fttacc_pkg::FPS_W-1:0]      rsp_frame_rate;
   logic [fttacc_pkg::ACC_W-1:0]      rsp_partial_tick;
   logic                              csr_we;
   logic [fttacc_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [fttacc_pkg::CSR_DATA_W-1:0] csr_wdata;

   // Predictor copy of configuration and state
   logic [fttacc_pkg::RATE_W-1:0]  model_rate;
   logic [fttacc_pkg::SCALE_W-1:0] model_scale;
   logic [63:0]                    model_prev;
   bit                             model_primed;
   logic [fttacc_pkg::ACC_W-1:0]   model_acc;

   frame_type                     pending_frames[$];
   stim_row_type                  directed[$];
   logic [fttacc_pkg::NOW_W-1:0]  stamp_ns;
   int                            mismatch_count;
   bit                            no_idle;
   bit                            long_hold_pending;

   fixed_timestep_tick_accumulator dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_now_ns       (req_now_ns),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_whole_ticks  (rsp_whole_ticks),
      .rsp_frame_rate   (rsp_frame_rate),
      .rsp_partial_tick (rsp_partial_tick),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // Generate the clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // End the run if results stop coming
   initial begin
      #20_000_000;
      $display("timeout: results still outstanding");
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   // Advance the predicted timer by one timestamp and return the frame it yields
   function automatic frame_type predict_frame(input logic [fttacc_pkg::NOW_W-1:0] now);
      logic [63:0]                  elapsed;
      logic [127:0]                 increment;
      logic [127:0]                 headroom;
      logic [fttacc_pkg::ACC_W-1:0] whole;
      frame_type                    f;
      elapsed = '0;
      f = '0;
      if (!model_primed) begin
         // first timestamp only sets the reference
         model_prev = {1'b0, now};
         model_primed = 1'b1;
      end else begin
         if ({1'b0, now} > model_prev) elapsed = {1'b0, now} - model_prev;
         model_prev = {1'b0, now};
         if (elapsed > SEC_NS) elapsed = SEC_NS;
         if (elapsed != 0) f.fps = fttacc_pkg::FPS_W'(SEC_NS / elapsed);
         // exact increment in Q16.32 ticks, truncated
         increment = ((128'(elapsed) * 128'(model_scale) * 128'(model_rate)) << 8)
                     / 128'(SEC_NS);
         headroom = 128'(fttacc_pkg::ACC_MAX - model_acc);
         if (increment >= headroom) model_acc = fttacc_pkg::ACC_MAX;
         else model_acc = model_acc + fttacc_pkg::ACC_W'(increment);
         whole = model_acc >> fttacc_pkg::ACC_FRAC_W;
         if (whole > fttacc_pkg::ACC_W'(fttacc_pkg::MAX_TICKS))
            whole = fttacc_pkg::ACC_W'(fttacc_pkg::MAX_TICKS);
         model_acc = model_acc - (whole << fttacc_pkg::ACC_FRAC_W);
         f.whole = fttacc_pkg::WHOLE_W'(whole);
      end
      f.partial = model_acc;
      return f;
   endfunction

   // Mostly short gaps, a few long ones
   function automatic int pick_gap();
      int unsigned r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 90) return $urandom_range(0, 3);
      return $urandom_range(20, 300);
   endfunction

   // Walk a frame clock forward, with the odd stall, backward step and wild jump
   function automatic logic [fttacc_pkg::NOW_W-1:0] next_stamp();
      int unsigned                  r;
      logic [fttacc_pkg::NOW_W-1:0] step;
      r = $urandom_range(0, 99);
      step = '0;
      if (r < 3) begin
         stamp_ns = fttacc_pkg::NOW_W'({$urandom, $urandom});
      end else if (r < 8) begin
         step = fttacc_pkg::NOW_W'($urandom_range(0, 2_000_000));
         stamp_ns = (stamp_ns > step) ? stamp_ns - step : '0;
      end else begin
         if (r < 12) step = '0;
         else if (r < 20) step = fttacc_pkg::NOW_W'($urandom_range(1, 1000));
         else if (r < 70) step = fttacc_pkg::NOW_W'($urandom_range(1_000_000, 50_000_000));
         else if (r < 80) step = fttacc_pkg::NOW_W'(999_999_999 + $urandom_range(0, 2));
         else if (r < 92)
            step = fttacc_pkg::NOW_W'($urandom_range(100_000_000, 2_000_000_000));
         else step = fttacc_pkg::NOW_W'({$urandom, 8'h00});
         stamp_ns = stamp_ns + step;
      end
      return stamp_ns;
   endfunction

   // Offer one timestamp and queue its expected frame once accepted
   task automatic send_frame(input logic [fttacc_pkg::NOW_W-1:0] now, input int gap,
                             input bit typed, input frame_type typed_frame);
      frame_type f;
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_now_ns <= now;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      f = predict_frame(now);
      pending_frames.push_back(typed ? typed_frame : f);
   endtask

   // Drop valid and wait until every expected frame is back
   task automatic wait_idle(input int extra);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_csr(input logic [fttacc_pkg::CSR_IDX_W-1:0] index,
                            input logic [fttacc_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      if (index == fttacc_pkg::CSR_TICK_RATE) model_rate = data;
      else model_scale = data[fttacc_pkg::SCALE_W-1:0];
   endtask

   task automatic add_item(input logic [fttacc_pkg::NOW_W-1:0] now);
      stim_row_type row;
      row = '{kind: ROW_ITEM, stamp: now, index: '0, data: '0, typed: 1'b0, frame: '0};
      directed.push_back(row);
   endtask

   task automatic add_typed(input logic [fttacc_pkg::NOW_W-1:0] now,
                            input logic [fttacc_pkg::WHOLE_W-1:0] whole,
                            input logic [fttacc_pkg::FPS_W-1:0] fps,
                            input logic [fttacc_pkg::ACC_W-1:0] partial);
      stim_row_type row;
      row = '{kind: ROW_ITEM, stamp: now, index: '0, data: '0, typed: 1'b1, frame: '0};
      row.frame.whole   = whole;
      row.frame.fps     = fps;
      row.frame.partial = partial;
      directed.push_back(row);
   endtask

   task automatic add_csr(input logic [fttacc_pkg::CSR_IDX_W-1:0] index,
                          input logic [fttacc_pkg::CSR_DATA_W-1:0] data);
      stim_row_type row;
      row = '{kind: ROW_CSR, stamp: '0, index: index, data: data, typed: 1'b0, frame: '0};
      directed.push_back(row);
   endtask

   // Check each result transaction against the oldest expectation
   always @(posedge clock) begin
      frame_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_frames.size() == 0) begin
            report_mismatch("result with no transaction pending");
         end else begin
            want = pending_frames.pop_front();
            if (rsp_whole_ticks !== want.whole)
               report_mismatch($sformatf("whole_ticks %0d, expected %0d",
                                         rsp_whole_ticks, want.whole));
            if (rsp_frame_rate !== want.fps)
               report_mismatch($sformatf("frame_rate %0d, expected %0d",
                                         rsp_frame_rate, want.fps));
            if (rsp_partial_tick !== want.partial)
               report_mismatch($sformatf("partial_tick %h, expected %h",
                                         rsp_partial_tick, want.partial));
         end
      end
   end

   // Drive result ready: random stalls, plus one long hold-off on request
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            rsp_ready <= 1'b0;
            for (int n = 0; n < LONG_HOLD; n++) @(negedge clock);
            rsp_ready <= 1'b1;
         end else if (stall_left != 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
      end
   end

   // Main sequence
   initial begin
      logic [fttacc_pkg::RATE_W-1:0]  rate_val;
      logic [fttacc_pkg::SCALE_W-1:0] scale_val;
      frame_type                      none;
      none = '0;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_now_ns = '0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      no_idle           = 1'b0;
      long_hold_pending = 1'b0;
      mismatch_count    = 0;
      model_rate   = fttacc_pkg::RATE_RESET;
      model_scale  = fttacc_pkg::SCALE_RESET;
      model_prev   = '0;
      model_primed = 1'b0;
      model_acc    = '0;

      // Directed table, reset configuration first (20 ticks/s, scale 1.0)
      add_typed(63'd1000, 7'd0, 30'd0, 48'd0);            // first timestamp only primes
      add_typed(63'd1000, 7'd0, 30'd0, 48'd0);            // no time elapsed
      add_typed(63'd1_000_001_000, 7'd20, 30'd1, 48'd0);  // exactly one second
      add_item(63'd1_000_001_001);                        // one nanosecond
      add_item(63'd500);                                  // time going backwards
      add_item(63'd5_000_000_500);                        // long gap, clamped
      add_item(63'h7FFF_FFFF_FFFF_FFFF);                  // largest timestamp
      add_item(63'd0);                                    // back to zero
      add_item(63'd16_666_667);                           // one frame at 60 Hz
      add_csr(fttacc_pkg::CSR_TICK_RATE, 32'hFFFF_FFFF);
      add_csr(fttacc_pkg::CSR_TIME_SCALE, 32'h0000_FFFF);
      // saturated accumulator, tick cap
      add_typed(63'd1_016_666_667, 7'd100, 30'd1, 48'hFF9B_FFFF_FFFF);
      add_item(63'd1_016_666_668);
      add_item(63'd2_016_666_668);
      add_csr(fttacc_pkg::CSR_TICK_RATE, 32'd0);
      add_item(63'd3_016_666_668);                        // drain backlog at zero rate
      add_csr(fttacc_pkg::CSR_TICK_RATE, 32'(fttacc_pkg::RATE_RESET));
      add_csr(fttacc_pkg::CSR_TIME_SCALE, 32'd0);
      add_item(63'd3_516_666_668);                        // paused time
      add_csr(fttacc_pkg::CSR_TIME_SCALE, 32'(fttacc_pkg::SCALE_RESET));
      add_item(63'd3_516_666_669);
      add_csr(fttacc_pkg::CSR_TICK_RATE, 32'd1);          // smallest nonzero rate
      add_item(63'd4_516_666_669);
      add_item(63'd5_516_666_668);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Walk the directed table
      foreach (directed[i]) begin
         if (directed[i].kind == ROW_CSR) begin
            wait_idle(4);
            write_csr(directed[i].index, directed[i].data);
         end else begin
            send_frame(directed[i].stamp, pick_gap(), directed[i].typed, directed[i].frame);
         end
      end
      stamp_ns = 63'd5_516_666_668;

      // Hold off results while offering back-to-back transactions
      long_hold_pending = 1'b1;
      repeat (24) send_frame(next_stamp(), 0, 1'b0, none);

      // Random phases, each with its own configuration
      for (int p = 0; p < PHASES; p++) begin
         wait_idle(4);
         if (p == 0) begin
            rate_val  = '1;
            scale_val = '1;
         end else if (p == 1) begin
            rate_val  = '0;
            scale_val = '0;
         end else begin
            case ($urandom_range(0, 4))
               0:       rate_val = $urandom;
               1:       rate_val = $urandom_range(1, 100 << 16);
               2:       rate_val = '1;
               default: rate_val = $urandom_range(1 << 16, 240 << 16);
            endcase
            case ($urandom_range(0, 4))
               0:       scale_val = fttacc_pkg::SCALE_W'($urandom_range(0, 65535));
               1:       scale_val = fttacc_pkg::SCALE_RESET;
               2:       scale_val = '1;
               default: scale_val = fttacc_pkg::SCALE_W'($urandom_range(64, 1024));
            endcase
         end
         write_csr(fttacc_pkg::CSR_TICK_RATE, rate_val);
         write_csr(fttacc_pkg::CSR_TIME_SCALE, 32'(scale_val));
         no_idle = ($urandom_range(0, 3) == 0);
         repeat (PHASE_ITEMS) send_frame(next_stamp(), pick_gap(), 1'b0, none);
      end
      no_idle = 1'b0;

      // Drain and finish
      wait_idle(TAIL_CYCLES);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/fttacc_pkg.sv
rtl/fttacc_mul.sv
rtl/fttacc_div.sv
rtl/fixed_timestep_tick_accumulator.sv
rtl/fttacc_checker.sv
tb/fixed_timestep_tick_accumulator_tb.sv
